/* hdl/fjot_pkg.sv */
// ----------------------------------------------------------------------------
// fjot_pkg: shared types and constants for the flat JSON object tokenizer
// Parse phase codes, character constants, error codes, the state, result and
// escape records, the whitespace test and the escape decoder.
// ----------------------------------------------------------------------------
package fjot_pkg;

  localparam int PHASE_W = 4;

  // Parse phase codes
  localparam logic [PHASE_W-1:0] PH_START      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_KEY_OR_END = 4'd1;
  localparam logic [PHASE_W-1:0] PH_KEY        = 4'd2;
  localparam logic [PHASE_W-1:0] PH_KEY_ESC    = 4'd3;
  localparam logic [PHASE_W-1:0] PH_COLON      = 4'd4;
  localparam logic [PHASE_W-1:0] PH_VAL_START  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_VAL        = 4'd6;
  localparam logic [PHASE_W-1:0] PH_VAL_ESC    = 4'd7;
  localparam logic [PHASE_W-1:0] PH_LIT        = 4'd8;
  localparam logic [PHASE_W-1:0] PH_AFTER_VAL  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_AFTER_OBJ  = 4'd10;
  localparam logic [PHASE_W-1:0] PH_DRAIN      = 4'd11;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_OPEN    = 3'd1;
  localparam logic [2:0] ERR_NO_KEY     = 3'd2;
  localparam logic [2:0] ERR_UNTERM     = 3'd3;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd4;
  localparam logic [2:0] ERR_NO_COLON   = 3'd5;
  localparam logic [2:0] ERR_NO_SEP     = 3'd6;
  localparam logic [2:0] ERR_TRAILING   = 3'd7;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               quoted;
  } state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       char_in_value;
    logic       key_done;
    logic       value_done;
    logic       value_quoted;
    logic       object_done;
    logic [2:0] error_code;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic esc_t unescape(input logic [7:0] e);
    esc_t r;
    r.ok = 1'b1;
    case (e)
      CH_QUOTE:  r.ch = CH_QUOTE;
      CH_BSLASH: r.ch = CH_BSLASH;
      CH_SLASH:  r.ch = CH_SLASH;
      CH_LC_B:   r.ch = CH_BS;
      CH_LC_F:   r.ch = CH_FF;
      CH_LC_N:   r.ch = CH_LF;
      CH_LC_R:   r.ch = CH_CR;
      CH_LC_T:   r.ch = CH_TAB;
      default: begin
        r.ok = 1'b0;
        r.ch = CH_NUL;
      end
    endcase
    unescape = r;
  endfunction

endpackage

/* hdl/flat_json_object_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer_top: byte-serial tokenizer for one flat object
// Input register, one-byte parse transition, result register.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte is loaded into the input register and moves on into
//   the result register once that register is free; a stall on the result
//   channel holds the result register and, behind it, the input register.
// Throughput: one byte per cycle while out_stall is low; phase moves with each byte.
// Reset (rst, synchronous, active high): both stages empty, phase waits for
//   the opening brace, quoted flag cleared.
module flat_json_object_tokenizer_top
  import fjot_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       char_in_value,
  output logic       key_done,
  output logic       value_done,
  output logic       value_quoted,
  output logic       object_done,
  output logic [2:0] error_code
);

  // input stage
  logic       in_full;
  logic [7:0] in_byte;
  // parser state and result stage
  state_t     st;
  state_t     st_next;
  res_t       step_res;
  res_t       out_res;
  logic       out_full;
  // pipeline control
  logic       advance;
  logic       move;

  // The result register frees up when empty or when its transaction completes;
  // the input stage holds only while its byte cannot move on.
  assign advance  = !out_full || !out_stall;
  assign move     = in_full && advance;
  assign in_stall = in_full && !advance;

  fjot_step u_step (
    .cur       (st),
    .text_byte (in_byte),
    .nxt       (st_next),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_full  <= 1'b0;
      st.phase  <= PH_START;
      st.quoted <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_full <= in_full;
      end
      // phase moves only when its byte is committed to the result register
      if (move) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= text_byte;
    end
    if (move) begin
      out_res <= step_res;
    end
  end

  assign out_valid     = out_full;
  assign out_char      = out_res.out_char;
  assign char_valid    = out_res.char_valid;
  assign char_in_value = out_res.char_in_value;
  assign key_done      = out_res.key_done;
  assign value_done    = out_res.value_done;
  assign value_quoted  = out_res.value_quoted;
  assign object_done   = out_res.object_done;
  assign error_code    = out_res.error_code;

  // a character result never carries an error or a key end
  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_valid) |-> (error_code == ERR_NONE && !key_done))
    else $error("character result with error or key end");

  // quoted flag only accompanies a finished value
  a_quoted_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && value_quoted) |-> value_done)
    else $error("value_quoted without value_done");

  // an error on a nonzero byte sends the parser into drain
  a_err_drain: assert property (@(posedge clk) disable iff (rst)
    (move && step_res.error_code != ERR_NONE && in_byte != CH_NUL)
      |=> (st.phase == PH_DRAIN))
    else $error("error did not enter drain");

  // any terminator byte returns the parser to the start
  a_nul_start: assert property (@(posedge clk) disable iff (rst)
    (move && in_byte == CH_NUL) |=> (st.phase == PH_START))
    else $error("terminator did not restart parser");

  // a result slot is filled only from a full input stage
  a_fill_src: assert property (@(posedge clk) disable iff (rst)
    (!out_full && !in_full) |=> !out_full)
    else $error("result appeared without a byte");

endmodule

/* hdl/fjot_step.sv */
// ----------------------------------------------------------------------------
// fjot_step: one-byte parse transition
// Combinational next state and result record for one text byte.
// ----------------------------------------------------------------------------
module fjot_step
  import fjot_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] text_byte,
  output state_t     nxt,
  output res_t       res
);

  logic             ws;
  logic             lit;
  logic [PHASE_W-1:0] fail_phase;
  esc_t             esc;

  assign ws         = is_ws(text_byte);
  assign fail_phase = (text_byte == CH_NUL) ? PH_START : PH_DRAIN;
  assign esc        = unescape(text_byte);

  always_comb begin
    res = '0;
    nxt = cur;
    lit = 1'b0;
    case (cur.phase)
      PH_START: begin
        if (!ws) begin
          if (text_byte == CH_LBRACE) begin
            nxt.phase = PH_KEY_OR_END;
          end else begin
            res.error_code = ERR_NO_OPEN;
            nxt.phase      = fail_phase;
          end
        end
      end
      PH_KEY_OR_END: begin
        if (!ws) begin
          if (text_byte == CH_RBRACE) begin
            nxt.phase = PH_AFTER_OBJ;
          end else if (text_byte == CH_QUOTE) begin
            nxt.phase = PH_KEY;
          end else begin
            res.error_code = ERR_NO_KEY;
            nxt.phase      = fail_phase;
          end
        end
      end
      PH_KEY, PH_VAL: begin
        if (text_byte == CH_NUL) begin
          res.error_code = ERR_UNTERM;
          nxt.phase      = PH_START;
        end else if (text_byte == CH_BSLASH) begin
          nxt.phase = (cur.phase == PH_KEY) ? PH_KEY_ESC : PH_VAL_ESC;
        end else if (text_byte == CH_QUOTE) begin
          if (cur.phase == PH_KEY) begin
            res.key_done = 1'b1;
            nxt.phase    = PH_COLON;
          end else begin
            res.value_done   = 1'b1;
            res.value_quoted = cur.quoted;
            nxt.phase        = PH_AFTER_VAL;
          end
        end else begin
          res.out_char      = text_byte;
          res.char_valid    = 1'b1;
          res.char_in_value = (cur.phase == PH_VAL);
        end
      end
      PH_KEY_ESC, PH_VAL_ESC: begin
        if (!esc.ok) begin
          res.error_code = ERR_BAD_ESC;
          nxt.phase      = fail_phase;
        end else begin
          res.out_char      = esc.ch;
          res.char_valid    = 1'b1;
          res.char_in_value = (cur.phase == PH_VAL_ESC);
          nxt.phase         = (cur.phase == PH_KEY_ESC) ? PH_KEY : PH_VAL;
        end
      end
      PH_COLON: begin
        if (!ws) begin
          if (text_byte == CH_COLON) begin
            nxt.phase = PH_VAL_START;
          end else begin
            res.error_code = ERR_NO_COLON;
            nxt.phase      = fail_phase;
          end
        end
      end
      PH_VAL_START: begin
        if (!ws) begin
          if (text_byte == CH_QUOTE) begin
            nxt.quoted = 1'b1;
            nxt.phase  = PH_VAL;
          end else begin
            // first byte of a bare literal, handled below
            nxt.quoted = 1'b0;
            nxt.phase  = PH_LIT;
            lit        = 1'b1;
          end
        end
      end
      PH_LIT: begin
        lit = 1'b1;
      end
      PH_AFTER_VAL: begin
        if (!ws) begin
          if (text_byte == CH_COMMA) begin
            nxt.phase = PH_KEY_OR_END;
          end else if (text_byte == CH_RBRACE) begin
            nxt.phase = PH_AFTER_OBJ;
          end else begin
            res.error_code = ERR_NO_SEP;
            nxt.phase      = fail_phase;
          end
        end
      end
      PH_AFTER_OBJ: begin
        if (!ws) begin
          if (text_byte == CH_NUL) begin
            res.object_done = 1'b1;
            nxt.phase       = PH_START;
          end else begin
            res.error_code = ERR_TRAILING;
            nxt.phase      = PH_DRAIN;
          end
        end
      end
      default: begin
        nxt.phase = fail_phase;
      end
    endcase

    // bare literal body
    if (lit) begin
      if (text_byte == CH_NUL || text_byte == CH_COMMA ||
          text_byte == CH_RBRACE || ws) begin
        res.value_done   = 1'b1;
        res.value_quoted = nxt.quoted;
        if (text_byte == CH_NUL) begin
          res.error_code = ERR_NO_SEP;
          nxt.phase      = PH_START;
        end else if (text_byte == CH_COMMA) begin
          nxt.phase = PH_KEY_OR_END;
        end else if (text_byte == CH_RBRACE) begin
          nxt.phase = PH_AFTER_OBJ;
        end else begin
          nxt.phase = PH_AFTER_VAL;
        end
      end else begin
        res.out_char      = text_byte;
        res.char_valid    = 1'b1;
        res.char_in_value = 1'b1;
      end
    end
  end

endmodule
